@@ rtl/core/mcs_pkg.sv @@
// Shared types and constants for the min-cost selector with hash tie-break.
// Holds the item action codes and the splitmix64 finalizer constants.
// No dependencies.
`timescale 1ns / 1ps

package mcs_pkg;

	// Action codes carried in the slave-side tuser field.
	typedef enum logic [2:0] {
		ACT_START  = 3'd0,
		ACT_CTX    = 3'd1,
		ACT_ALT    = 3'd2,
		ACT_CLOSE  = 3'd3,
		ACT_FINISH = 3'd4
	} action_t;

	// Splitmix64 finalizer constants.
	localparam logic [63:0] GOLDEN = 64'h9e37_79b9_7f4a_7c15;
	localparam logic [63:0] MUL_A  = 64'hbf58_476d_1ce4_e5b9;
	localparam logic [63:0] MUL_B  = 64'h94d0_49bb_1331_11eb;
	localparam int unsigned SHIFT_1 = 30;
	localparam int unsigned SHIFT_2 = 27;
	localparam int unsigned SHIFT_3 = 31;

	// Field widths of the stream words.
	localparam int unsigned BYTE_W  = 8;
	localparam int unsigned COST_W  = 32;
	localparam int unsigned HASH_W  = 64;
	localparam int unsigned INDEX_W = 8;
	localparam int unsigned IN_TDATA_W  = 48;
	localparam int unsigned OUT_TDATA_W = 112;

endpackage

@@ rtl/core/min_cost_select_hash_tiebreak_unit.sv @@
// Min-cost candidate selector with a splitmix64 hash tie-break.
// Context and alternative byte words go through the hash unit, which runs
// its shared 32x32 multiplier three times per 64-bit multiply, twice per byte.
// Start, close and finish words need no hash; a finish result is registered
// and shows on the master side the cycle after the word is accepted.
// Asynchronous active-low reset resets all state and loads a zero seed.
`timescale 1ns / 1ps

module min_cost_select_hash_tiebreak_unit
	import mcs_pkg::*;
#(
	parameter int unsigned MAX_CANDIDATES = 256,
	parameter int unsigned COST_BITS      = 32
) (
	input  logic                   clk,
	input  logic                   arst_n,
	// Configuration: seed
	input  logic                   cfg_valid,
	output logic                   cfg_ready,
	input  logic [HASH_W-1:0]      cfg_data,
	// Slave side
	input  logic                   s_tvalid,
	output logic                   s_tready,
	// data_byte[7:0], cost[39:8], eligible[40], zero pad [47:41]
	input  logic [IN_TDATA_W-1:0]  s_tdata,
	// action[2:0]
	input  logic [2:0]             s_tuser,
	// Master side
	output logic                   m_tvalid,
	input  logic                   m_tready,
	// found[0], best_index[8:1], best_cost[40:9], best_hash[104:41],
	// overflow[105], zero pad [111:106]
	output logic [OUT_TDATA_W-1:0] m_tdata
);

	localparam int unsigned CNT_W = $clog2(MAX_CANDIDATES + 1);
	localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_CANDIDATES);
	localparam logic [COST_W-1:0] COST_MASK =
		(COST_BITS >= COST_W) ? {COST_W{1'b1}} : COST_W'((64'd1 << COST_BITS) - 64'd1);

	typedef enum logic {
		S_IDLE,
		S_HASH
	} state_t;

	state_t              state_q;
	logic                is_ctx_q;
	logic [HASH_W-1:0]   seed_q;
	logic [HASH_W-1:0]   prefix_hash_q;
	logic [HASH_W-1:0]   cand_hash_q;
	logic                have_best_q;
	logic [COST_W-1:0]   chosen_cost_q;
	logic [HASH_W-1:0]   chosen_hash_q;
	logic [INDEX_W-1:0]  chosen_index_q;
	logic [CNT_W-1:0]    count_q;
	logic                dropped_q;
	logic                out_valid_q;
	logic [OUT_TDATA_W-1:0] out_data_q;

	logic                accept;
	action_t             action;
	logic [BYTE_W-1:0]   in_byte;
	logic [COST_W-1:0]   in_cost;
	logic                in_elig;
	logic                hash_start;
	logic [HASH_W-1:0]   hash_in;
	logic                hash_done;
	logic [HASH_W-1:0]   hash_out;
	logic                take;

	// Unpack the slave-side word.
	assign action  = action_t'(s_tuser);
	assign in_byte = s_tdata[7:0];
	assign in_cost = s_tdata[39:8] & COST_MASK;
	assign in_elig = s_tdata[40];

	assign cfg_ready = 1'b1;
	assign s_tready  = (state_q == S_IDLE) && (!out_valid_q || m_tready);
	assign accept    = s_tvalid && s_tready;

	// Byte words start the hash unit from the prefix or candidate hash.
	assign hash_start = accept && ((action == ACT_CTX) || (action == ACT_ALT));
	assign hash_in    = ((action == ACT_CTX) ? prefix_hash_q : cand_hash_q)
		^ HASH_W'(in_byte);

	mcs_hash_unit u_hash (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (hash_start),
		.value_in (hash_in),
		.done     (hash_done),
		.result   (hash_out)
	);

	// Selection compare: lower cost wins, then lower hash.
	assign take = !have_best_q || (in_cost < chosen_cost_q)
		|| ((in_cost == chosen_cost_q) && (cand_hash_q < chosen_hash_q));

	// Seed register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seed_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			seed_q <= cfg_data;
		end
	end

	// Sequencer and selection state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= S_IDLE;
			is_ctx_q       <= 1'b0;
			prefix_hash_q  <= '0;
			cand_hash_q    <= '0;
			have_best_q    <= 1'b0;
			chosen_cost_q  <= '0;
			chosen_hash_q  <= '1;
			chosen_index_q <= '0;
			count_q        <= '0;
			dropped_q      <= 1'b0;
			out_valid_q    <= 1'b0;
			out_data_q     <= '0;
		end else begin
			// A new finish word refills the output register as the old one leaves.
			if (accept && (action == ACT_FINISH)) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && m_tready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						case (action)
							ACT_START: begin
								prefix_hash_q  <= seed_q;
								cand_hash_q    <= seed_q;
								have_best_q    <= 1'b0;
								chosen_cost_q  <= '0;
								chosen_hash_q  <= '1;
								chosen_index_q <= '0;
								count_q        <= '0;
								dropped_q      <= 1'b0;
							end
							ACT_CTX, ACT_ALT: begin
								is_ctx_q <= (action == ACT_CTX);
								state_q  <= S_HASH;
							end
							ACT_CLOSE: begin
								if (count_q >= CNT_MAX) begin
									dropped_q <= 1'b1;
								end else begin
									if (in_elig && take) begin
										have_best_q    <= 1'b1;
										chosen_cost_q  <= in_cost;
										chosen_hash_q  <= cand_hash_q;
										chosen_index_q <= INDEX_W'(count_q);
									end
									count_q <= CNT_W'(count_q + 1'b1);
								end
								cand_hash_q <= prefix_hash_q;
							end
							ACT_FINISH: begin
								out_data_q  <= {6'd0, dropped_q,
									have_best_q ? chosen_hash_q : {HASH_W{1'b0}},
									have_best_q ? chosen_cost_q : {COST_W{1'b0}},
									have_best_q ? chosen_index_q : {INDEX_W{1'b0}},
									have_best_q};
							end
							default: begin
								state_q <= S_IDLE;
							end
						endcase
					end
				end
				S_HASH: begin
					if (hash_done) begin
						cand_hash_q <= hash_out;
						if (is_ctx_q) begin
							prefix_hash_q <= hash_out;
						end
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;

endmodule

@@ rtl/core/mcs_hash_unit.sv @@
// Iterative splitmix64 finalizer built around one shared 32x32 multiplier.
// Each 64-bit multiply modulo 2^64 is done as three partial products.
// Depends on mcs_pkg.
`timescale 1ns / 1ps

module mcs_hash_unit
	import mcs_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [63:0] value_in,
	output logic        done,
	output logic [63:0] result
);

	typedef enum logic [2:0] {
		H_IDLE,
		H_ADDG,
		H_MIX,
		H_MUL0,
		H_MUL1,
		H_MUL2,
		H_NEXT
	} hstate_t;

	hstate_t     state_q;
	logic        round_q;
	logic [63:0] x_q;
	logic [63:0] acc_q;
	logic [63:0] result_q;
	logic        done_q;

	logic [63:0] mul_k;
	logic [31:0] op_a;
	logic [31:0] op_b;
	logic [63:0] prod;

	// Operand selection for the shared multiplier: low*low, low*high, high*low.
	always_comb begin
		mul_k = round_q ? MUL_B : MUL_A;
		op_a  = x_q[31:0];
		op_b  = mul_k[31:0];
		case (state_q)
			H_MUL1: begin
				op_b = mul_k[63:32];
			end
			H_MUL2: begin
				op_a = x_q[63:32];
			end
			default: begin
				op_a = x_q[31:0];
			end
		endcase
		prod = 64'(op_a) * 64'(op_b);
	end

	// Sequencer: add golden ratio, mix, multiply, mix, multiply, final mix.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= H_IDLE;
			round_q  <= 1'b0;
			done_q   <= 1'b0;
			x_q      <= '0;
			acc_q    <= '0;
			result_q <= '0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				H_IDLE: begin
					if (start) begin
						x_q     <= value_in;
						state_q <= H_ADDG;
					end
				end
				H_ADDG: begin
					x_q     <= x_q + GOLDEN;
					state_q <= H_MIX;
				end
				H_MIX: begin
					x_q     <= x_q ^ (x_q >> SHIFT_1);
					round_q <= 1'b0;
					state_q <= H_MUL0;
				end
				H_MUL0: begin
					acc_q   <= prod;
					state_q <= H_MUL1;
				end
				H_MUL1: begin
					acc_q[63:32] <= acc_q[63:32] + prod[31:0];
					state_q      <= H_MUL2;
				end
				H_MUL2: begin
					acc_q[63:32] <= acc_q[63:32] + prod[31:0];
					state_q      <= H_NEXT;
				end
				H_NEXT: begin
					if (!round_q) begin
						x_q     <= acc_q ^ (acc_q >> SHIFT_2);
						round_q <= 1'b1;
						state_q <= H_MUL0;
					end else begin
						result_q <= acc_q ^ (acc_q >> SHIFT_3);
						done_q   <= 1'b1;
						state_q  <= H_IDLE;
					end
				end
				default: begin
					state_q <= H_IDLE;
				end
			endcase
		end
	end

	assign done   = done_q;
	assign result = result_q;

endmodule
